[hdl/prq_pkg.sv]
// Shared types and codes for the priority request queue.
`timescale 1ns / 1ps

package prq_pkg;

   // Operation codes of an input item
   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_QUERY  = 2'd2,
      OP_SPARE  = 2'd3
   } op_type;

   // Result status codes
   typedef enum logic [2:0] {
      ST_INSERTED     = 3'd0,
      ST_REMOVED      = 3'd1,
      ST_REMOVE_EMPTY = 3'd2,
      ST_INSERT_FULL  = 3'd3,
      ST_QUERY        = 3'd4
   } status_type;

   // One stored request
   typedef struct packed {
      logic [2:0]  urgency;
      logic [31:0] arrival_time;
      logic [15:0] tag;
   } entry_type;

   // Memory access from the sequencer to the entry store
   typedef struct packed {
      logic      wr_en;
      entry_type wr_data;
   } store_ctl_type;

endpackage

[hdl/prq_ram.sv]
// Entry store: one write port and one registered read port.
`timescale 1ns / 1ps

module prq_ram
   import prq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  store_ctl_type            ctl,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output entry_type                rd_data
);

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[wr_addr] <= ctl.wr_data;
      end
   end

   // Register the read data
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/prq_beats.sv]
// Compare unit: true when entry a is served strictly before entry b.
`timescale 1ns / 1ps

module prq_beats
   import prq_pkg::*;
(
   input  entry_type a,
   input  entry_type b,
   output logic      beats
);

   // Higher urgency wins, then the earlier arrival
   always_comb begin
      if (a.urgency != b.urgency) begin
         beats = a.urgency > b.urgency;
      end else begin
         beats = a.arrival_time < b.arrival_time;
      end
   end

endmodule

[hdl/priority_request_queue.sv]
// Priority request queue: sequencer around a ring-addressed sorted store.
//
// A bounded queue kept sorted best first in a single-port-read memory used
// as a ring. start is taken when busy is low; the result shows for one cycle
// on rsp_valid in the cycle after the item finishes. A status query, a
// remove from an empty queue and an insert into a full queue finish at once
// (busy stays low, result the next cycle). A remove reads the head entry
// in S_REM_RD, then hands it out and advances the ring head in S_REM_OUT.
// An insert walks from the tail toward the head, each entry through S_INS_RD
// (memory read), then S_INS_CMP (one compare and one write), moving each
// entry that the new request beats one place back, using the one comparator
// and the registered memory read. Results cannot be stalled: the receiver
// must take every strobe.
`timescale 1ns / 1ps

module priority_request_queue
   import prq_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [2:0]  req_urgency,
   input  logic [31:0] req_arrival_time,
   input  logic [15:0] req_request_tag,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [2:0]  rsp_out_urgency,
   output logic [31:0] rsp_out_arrival_time,
   output logic [15:0] rsp_out_tag,
   output logic [4:0]  rsp_occupancy
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [IDX_W:0]   CAP_SUM = (IDX_W + 1)'(CAPACITY);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_INS_RD  = 6'b000010,
      S_INS_CMP = 6'b000100,
      S_INS_PUT = 6'b001000,
      S_REM_RD  = 6'b010000,
      S_REM_OUT = 6'b100000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   entry_type        fresh_ff, fresh_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   entry_type        rsp_entry_ff, rsp_entry_in;
   logic [4:0]       rsp_occ_ff, rsp_occ_in;

   logic [IDX_W-1:0] logical_idx;
   logic [IDX_W:0]   ring_sum;
   logic [IDX_W-1:0] phys_addr;
   logic [IDX_W:0]   head_sum;
   store_ctl_type    store_ctl;
   entry_type        rd_data;
   logic             fresh_beats;
   logic             accept;

   assign accept = start && (state_ff == S_IDLE);

   // Map a logical position onto the ring
   always_comb begin
      if (state_ff == S_INS_RD) begin
         logical_idx = IDX_W'(pos_ff - CNT_W'(1));
      end else begin
         logical_idx = pos_ff[IDX_W-1:0];
      end
      ring_sum = {1'b0, head_ff} + {1'b0, logical_idx};
      if (ring_sum >= CAP_SUM) begin
         phys_addr = IDX_W'(ring_sum - CAP_SUM);
      end else begin
         phys_addr = ring_sum[IDX_W-1:0];
      end
      head_sum = {1'b0, head_ff} + (IDX_W + 1)'(1);
   end

   prq_beats u_beats (
      .a     (fresh_ff),
      .b     (rd_data),
      .beats (fresh_beats)
   );

   prq_ram #(
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .ctl     (store_ctl),
      .wr_addr (phys_addr),
      .rd_addr (phys_addr),
      .rd_data (rd_data)
   );

   // Sequence one item
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      head_in        = head_ff;
      pos_in         = pos_ff;
      fresh_in       = fresh_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_entry_in   = rsp_entry_ff;
      rsp_occ_in     = rsp_occ_ff;
      store_ctl      = '{wr_en: 1'b0, wr_data: fresh_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               fresh_in     = '{urgency: req_urgency, arrival_time: req_arrival_time,
                                tag: req_request_tag};
               rsp_entry_in = '0;
               rsp_occ_in   = 5'(count_ff);
               unique case (op_type'(req_operation))
                  OP_INSERT: begin
                     if (count_ff >= CAP_CNT) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_INSERT_FULL;
                     end else if (count_ff == '0) begin
                        pos_in   = '0;
                        state_in = S_INS_PUT;
                     end else begin
                        pos_in   = count_ff;
                        state_in = S_INS_RD;
                     end
                  end
                  OP_REMOVE: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_REMOVE_EMPTY;
                     end else begin
                        pos_in   = '0;
                        state_in = S_REM_RD;
                     end
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_QUERY;
                  end
               endcase
            end
         end
         S_INS_RD: begin
            state_in = S_INS_CMP;
         end
         S_INS_CMP: begin
            // Move the beaten entry back one place, or drop the new one in
            store_ctl.wr_en = 1'b1;
            if (fresh_beats) begin
               store_ctl.wr_data = rd_data;
               pos_in            = pos_ff - CNT_W'(1);
               state_in          = (pos_ff == CNT_W'(1)) ? S_INS_PUT : S_INS_RD;
            end else begin
               count_in      = count_ff + CNT_W'(1);
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_INSERTED;
               rsp_occ_in    = 5'(count_ff + CNT_W'(1));
               state_in      = S_IDLE;
            end
         end
         S_INS_PUT: begin
            store_ctl.wr_en = 1'b1;
            count_in        = count_ff + CNT_W'(1);
            rsp_valid_in    = 1'b1;
            rsp_status_in   = ST_INSERTED;
            rsp_occ_in      = 5'(count_ff + CNT_W'(1));
            state_in        = S_IDLE;
         end
         S_REM_RD: begin
            state_in = S_REM_OUT;
         end
         S_REM_OUT: begin
            // Hand out the head entry and advance the ring
            rsp_entry_in  = rd_data;
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_REMOVED;
            rsp_occ_in    = 5'(count_ff - CNT_W'(1));
            count_in      = count_ff - CNT_W'(1);
            head_in       = (head_sum >= CAP_SUM) ? '0 : head_sum[IDX_W-1:0];
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      fresh_ff      <= fresh_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign busy                 = (state_ff != S_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_out_urgency      = rsp_entry_ff.urgency;
   assign rsp_out_arrival_time = rsp_entry_ff.arrival_time;
   assign rsp_out_tag          = rsp_entry_ff.tag;
   assign rsp_occupancy        = rsp_occ_ff;

   // Every finished multi-cycle item leaves exactly one result behind
   a_done_strobe : assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("item finished without a result strobe");

   // An accepted item either works on or reports in the next cycle
   a_accept_moves : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted item lost");

   // Occupancy never exceeds the store
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("entry count above capacity");

   // An empty-remove report sees an empty queue
   a_empty_report : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_REMOVE_EMPTY) |-> (count_ff == '0))
      else $error("remove-empty reported with entries held");

endmodule

[test/priority_request_queue_tb.sv]
// Self-checking testbench for the priority request queue.
`timescale 1ns / 1ps

module priority_request_queue_tb
   import prq_pkg::*;
();

   localparam int CAPACITY     = 16;
   localparam int RANDOM_ITEMS = 1425;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 2 * CAPACITY + 10;
   localparam int REPORT_LIMIT = 10;

   // One result as seen on the rsp_ ports
   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  urgency;
      logic [31:0] arrival_time;
      logic [15:0] tag;
      logic [4:0]  occupancy;
   } response_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_operation;
   logic [2:0]  req_urgency;
   logic [31:0] req_arrival_time;
   logic [15:0] req_request_tag;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [2:0]  rsp_out_urgency;
   logic [31:0] rsp_out_arrival_time;
   logic [15:0] rsp_out_tag;
   logic [4:0]  rsp_occupancy;

   // Shadow copy of the sorted store, best entry first
   entry_type   sorted_entries [CAPACITY];
   int          entry_total;
   logic [31:0] insert_total;
   int          remove_total;
   int          full_reject_total;
   int          empty_remove_total;
   int          query_total;
   int          item_total;
   int          result_total;
   int          mismatch_count;
   int          cycle_count;

   response_type expected_responses [$];
   response_type observed;
   response_type wanted;

   priority_request_queue #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_operation(req_operation),
      .req_urgency(req_urgency),
      .req_arrival_time(req_arrival_time),
      .req_request_tag(req_request_tag),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_out_urgency(rsp_out_urgency),
      .rsp_out_arrival_time(rsp_out_arrival_time),
      .rsp_out_tag(rsp_out_tag),
      .rsp_occupancy(rsp_occupancy)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // True when entry a is served strictly ahead of entry b
   function automatic logic outranks(entry_type a, entry_type b);
      if (a.urgency != b.urgency)
         return a.urgency > b.urgency;
      return a.arrival_time < b.arrival_time;
   endfunction

   // Apply one accepted item to the shadow store and queue its result
   task automatic predict_response(op_type op, logic [2:0] urg, logic [31:0] arr,
                                   logic [15:0] tag);
      entry_type    fresh;
      response_type resp;
      int           pos;
      resp = '0;
      case (op)
         OP_INSERT: begin
            if (entry_total >= CAPACITY) begin
               resp.status = ST_INSERT_FULL;
               full_reject_total++;
            end else begin
               fresh.urgency      = urg;
               fresh.arrival_time = arr;
               fresh.tag          = tag;
               // new entry goes behind everything at least as good
               pos = 0;
               while (pos < entry_total && !outranks(fresh, sorted_entries[pos]))
                  pos++;
               for (int k = entry_total; k > pos; k--)
                  sorted_entries[k] = sorted_entries[k - 1];
               sorted_entries[pos] = fresh;
               entry_total++;
               insert_total++;
               resp.status = ST_INSERTED;
            end
         end
         OP_REMOVE: begin
            if (entry_total == 0) begin
               resp.status = ST_REMOVE_EMPTY;
               empty_remove_total++;
            end else begin
               resp.status       = ST_REMOVED;
               resp.urgency      = sorted_entries[0].urgency;
               resp.arrival_time = sorted_entries[0].arrival_time;
               resp.tag          = sorted_entries[0].tag;
               for (int k = 1; k < entry_total; k++)
                  sorted_entries[k - 1] = sorted_entries[k];
               entry_total--;
               remove_total++;
            end
         end
         default: begin
            resp.status = ST_QUERY;
            query_total++;
         end
      endcase
      resp.occupancy = 5'(entry_total);
      expected_responses.push_back(resp);
   endtask

   // Present one item and hold it until the transfer happens
   task automatic send_item(op_type op, logic [2:0] urg, logic [31:0] arr,
                            logic [15:0] tag);
      start            <= 1'b1;
      req_operation    <= op;
      req_urgency      <= urg;
      req_arrival_time <= arr;
      req_request_tag  <= tag;
      @(posedge clock);
      while (busy !== 1'b0)
         @(posedge clock);
      item_total++;
      predict_response(op, urg, arr, tag);
   endtask

   // Drop start for a gap and scramble the idle request fields
   task automatic pause_sender(int cycles);
      start            <= 1'b0;
      req_operation    <= 2'($urandom);
      req_urgency      <= 3'($urandom);
      req_arrival_time <= $urandom;
      req_request_tag  <= 16'($urandom);
      repeat (cycles) @(posedge clock);
   endtask

   task automatic log_mismatch(string what, response_type want, response_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("mismatch (%s): expected st=%0d urg=%0d arr=%h tag=%h occ=%0d",
                  what, want.status, want.urgency, want.arrival_time, want.tag,
                  want.occupancy);
         $display("   actual st=%0d urg=%0d arr=%h tag=%h occ=%0d",
                  got.status, got.urgency, got.arrival_time, got.tag, got.occupancy);
      end
   endtask

   // Check each result strobe against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid !== 1'b0) begin
         observed.status       = rsp_status;
         observed.urgency      = rsp_out_urgency;
         observed.arrival_time = rsp_out_arrival_time;
         observed.tag          = rsp_out_tag;
         observed.occupancy    = rsp_occupancy;
         result_total++;
         if (expected_responses.size() == 0 || rsp_valid !== 1'b1) begin
            log_mismatch("unexpected strobe", '0, observed);
         end else begin
            wanted = expected_responses.pop_front();
            if (observed !== wanted)
               log_mismatch("result", wanted, observed);
         end
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("cycle limit hit with %0d results outstanding",
                  expected_responses.size());
         $display("priority_request_queue_tb NOT OK");
         $finish;
      end
   end

   // Remove and query on an empty queue, spare opcode acts as a query
   task automatic test_empty_queue();
      send_item(OP_REMOVE, 3'd7, 32'hFFFF_FFFF, 16'hFFFF);
      send_item(OP_QUERY, 3'd0, 32'h0, 16'h0);
      send_item(OP_SPARE, 3'd7, 32'hFFFF_FFFF, 16'hFFFF);
   endtask

   // Fill to capacity with extremes, equal keys and full ties
   task automatic test_ordering();
      send_item(OP_INSERT, 3'd3, 32'd100, 16'h0001);
      send_item(OP_INSERT, 3'd3, 32'd100, 16'h0002);
      send_item(OP_INSERT, 3'd3, 32'd50, 16'h0003);
      send_item(OP_INSERT, 3'd7, 32'hFFFF_FFFF, 16'hFFFF);
      send_item(OP_INSERT, 3'd0, 32'h0, 16'h0000);
      send_item(OP_INSERT, 3'd7, 32'h0, 16'h1234);
      send_item(OP_INSERT, 3'd0, 32'hFFFF_FFFF, 16'hAAAA);
      pause_sender(3);
      send_item(OP_INSERT, 3'd5, 32'h8000_0000, 16'h5555);
      send_item(OP_INSERT, 3'd5, 32'h7FFF_FFFF, 16'h0F0F);
      send_item(OP_INSERT, 3'd3, 32'd100, 16'h0004);
      send_item(OP_INSERT, 3'd7, 32'hFFFF_FFFF, 16'hFFFE);
      send_item(OP_INSERT, 3'd1, 32'd1, 16'h8000);
      send_item(OP_INSERT, 3'd6, 32'hDEAD_BEEF, 16'h00FF);
      send_item(OP_INSERT, 3'd2, 32'h1234_5678, 16'hFF00);
      send_item(OP_INSERT, 3'd4, 32'hFFFF_FFFE, 16'h7FFF);
      send_item(OP_INSERT, 3'd0, 32'h0, 16'h0001);
   endtask

   // Reject an insert when full, then make room and insert at the top
   task automatic test_full_queue();
      send_item(OP_INSERT, 3'd7, 32'h0, 16'hBEEF);
      send_item(OP_QUERY, 3'd7, 32'hFFFF_FFFF, 16'hFFFF);
      send_item(OP_REMOVE, 3'd0, 32'h0, 16'h0);
      send_item(OP_REMOVE, 3'd0, 32'h0, 16'h0);
      pause_sender(1);
      send_item(OP_REMOVE, 3'd0, 32'h0, 16'h0);
      send_item(OP_INSERT, 3'd7, 32'h0, 16'hCAFE);
   endtask

   task automatic send_random_item(int insert_pct);
      op_type      op;
      logic [2:0]  urg;
      logic [31:0] arr;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 4)
         op = OP_QUERY;
      else if (pick < 6)
         op = OP_SPARE;
      else if ($urandom_range(0, 99) < insert_pct)
         op = OP_INSERT;
      else
         op = OP_REMOVE;
      urg = 3'($urandom_range(0, 7));
      // narrow timestamps make ties common
      case ($urandom_range(0, 4))
         0, 1: arr = $urandom_range(0, 7);
         2: arr = $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 3)
                                       : 32'($urandom_range(0, 3));
         default: arr = $urandom;
      endcase
      send_item(op, urg, arr, 16'($urandom));
   endtask

   // Bursts of traffic that swing the queue between empty and full
   task automatic test_random_traffic();
      int sent;
      int burst;
      int insert_pct;
      bit calm;
      sent       = 0;
      insert_pct = 50;
      calm       = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 2))
               0: insert_pct = 90;
               1: insert_pct = 50;
               default: insert_pct = 10;
            endcase
         end
         if ($urandom_range(0, 9) == 0)
            calm = !calm;
         burst = $urandom_range(1, 24);
         for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
            send_random_item(insert_pct);
            sent++;
         end
         if (!calm)
            pause_sender(($urandom_range(0, 4) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(1, 6));
      end
   endtask

   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_operation    = OP_QUERY;
      req_urgency      = '0;
      req_arrival_time = '0;
      req_request_tag  = '0;
      entry_total        = 0;
      insert_total       = '0;
      remove_total       = 0;
      full_reject_total  = 0;
      empty_remove_total = 0;
      query_total        = 0;
      item_total         = 0;
      result_total       = 0;
      mismatch_count     = 0;
      cycle_count        = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_empty_queue();
      test_ordering();
      test_full_queue();
      test_random_traffic();

      // Drain outstanding results, then watch for stray strobes
      start <= 1'b0;
      while (expected_responses.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d items (%0d ins, %0d rem, %0d full, %0d empty, %0d query)",
               item_total, insert_total, remove_total, full_reject_total,
               empty_remove_total, query_total);
      $display("checked %0d results, %0d mismatches", result_total, mismatch_count);
      if (mismatch_count == 0 && expected_responses.size() == 0)
         $display("priority_request_queue_tb OK");
      else
         $display("priority_request_queue_tb NOT OK");
      $finish;
   end

endmodule
